// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for clocked properties with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ltb_pkg.sv =====
// ----------------------------------------------------------------------------
// ltb_pkg
// Shared types and constants of the timing budget calculator.
// ----------------------------------------------------------------------------
package ltb_pkg;

  localparam logic [31:0] MAX_REMAINDER_US = 32'd1100000;
  localparam logic [31:0] PHASECAL_US      = 32'd1000;
  localparam logic [11:0] MACRO_VCSEL_PER  = 12'd2304;
  localparam logic [31:0] PLL_NUM          = 32'h4000_0000;
  localparam logic [63:0] ROUND_HALF       = 64'h800;
  localparam logic [7:0]  PC_SAT           = 8'hFF;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LOW_BUDG  = 2'd1;
  localparam logic [1:0] ST_HIGH_BUDG = 2'd2;

  localparam logic [3:0] REG_OSC   = 4'd0;
  localparam logic [3:0] REG_GUARD = 4'd1;

  // conversion slots of a kind 0 item
  localparam logic [2:0] SLOT_PC  = 3'd0;
  localparam logic [2:0] SLOT_MMA = 3'd1;
  localparam logic [2:0] SLOT_RA  = 3'd2;
  localparam logic [2:0] SLOT_MMB = 3'd3;
  localparam logic [2:0] SLOT_RB  = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FAIL1,
    OP_FAIL2,
    OP_PLL,
    OP_MAC1,
    OP_MAC2,
    OP_CONV,
    OP_ENC,
    OP_STORE,
    OP_DMUL,
    OP_DFIN
  } ltb_op_t;

  typedef struct packed {
    ltb_op_t    op;
    logic [2:0] slot;
  } ltb_cmd_t;

  typedef struct packed {
    logic kind;
    logic le_guard;
    logic too_big;
    logic div_busy;
    logic enc_busy;
  } ltb_sts_t;

endpackage

// ===== hw/rtl/ltb_div.sv =====
// ----------------------------------------------------------------------------
// ltb_div
// Restoring 32/32 divider, one quotient bit per cycle. Zero divisor gives
// all ones.
// ----------------------------------------------------------------------------
module ltb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] quot
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [31:0] d_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial   = {rem_r, q_r[31]};
    diff    = trial - {1'b0, d_r};
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (!diff[32]) begin
      rem_nxt = diff[31:0];
      q_nxt   = {q_r[30:0], 1'b1};
    end else begin
      rem_nxt = trial[31:0];
      q_nxt   = {q_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
      q_r    <= num;
      d_r    <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

// ===== hw/rtl/ltb_datapath.sv =====
// ----------------------------------------------------------------------------
// ltb_datapath
// Registers, multipliers, shared divider and count encoder of the calculator.
// ----------------------------------------------------------------------------
module ltb_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  ltb_pkg::ltb_cmd_t cmd,
  output ltb_pkg::ltb_sts_t sts,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             in_kind,
  input  logic [31:0]      in_budget_us,
  input  logic [7:0]       in_vcsel_period_a,
  input  logic [7:0]       in_vcsel_period_b,
  input  logic [15:0]      in_encoded_timeout_a,
  output logic [1:0]       out_status,
  output logic [7:0]       out_phasecal_timeout,
  output logic [15:0]      out_mm_timeout_a,
  output logic [15:0]      out_range_timeout_a,
  output logic [15:0]      out_mm_timeout_b,
  output logic [15:0]      out_range_timeout_b,
  output logic [31:0]      out_budget_out_us
);
  import ltb_pkg::*;

  logic [15:0] osc_r, guard_r;
  logic        kind_r, le_r, big_r;
  logic [7:0]  code_a_r, code_b_r;
  logic [15:0] enc_in_r;
  logic [19:0] half_r;
  logic [25:0] m1_r;
  logic [31:0] macro_r;
  logic [63:0] prod_r;
  logic [31:0] enc_v_r;
  logic [4:0]  enc_e_r;
  logic        enc_zero_r, enc_busy_r;

  logic [1:0]  status_r;
  logic [7:0]  pc_r;
  logic [15:0] mma_r, ra_r, mmb_r, rb_r;
  logic [31:0] bout_r;

  logic        div_start, div_busy;
  logic [31:0] div_num, div_den, div_q;

  logic [31:0] rem_full;
  logic [31:0] conv_us;
  logic [7:0]  code_sel;
  logic [7:0]  pclks;
  logic [43:0] m1_prod;
  logic [33:0] m2_prod;
  logic [31:0] dec_cnt;
  logic [31:0] enc_v0;
  logic [63:0] round_sum;
  logic [31:0] us_dec;
  logic [15:0] enc_word;

  ltb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_q)
  );

  always_comb begin
    rem_full = in_budget_us - {16'd0, guard_r};
    unique case (cmd.slot)
      SLOT_PC:            conv_us = PHASECAL_US;
      SLOT_MMA, SLOT_MMB: conv_us = 32'd1;
      default:            conv_us = {12'd0, half_r};
    endcase
    code_sel  = (cmd.slot >= SLOT_MMB) ? code_b_r : code_a_r;
    pclks     = {code_sel[6:0] + 7'd1, 1'b0};
    m1_prod   = {32'd0, MACRO_VCSEL_PER} * {12'd0, div_q};
    m2_prod   = {8'd0, m1_r} * {26'd0, pclks};
    div_start = (cmd.op == OP_PLL) || (cmd.op == OP_CONV);
    if (cmd.op == OP_PLL) begin
      div_num = PLL_NUM;
      div_den = {16'd0, osc_r};
    end else begin
      div_num = (conv_us << 12) + {1'b0, macro_r[31:1]};
      div_den = macro_r;
    end
    // decode: mantissa shifted by exponent, nothing left past 31
    dec_cnt   = ((enc_in_r[15:13] == 3'd0) ?
                 ({24'd0, enc_in_r[7:0]} << enc_in_r[12:8]) : 32'd0) + 32'd1;
    enc_v0    = div_q - 32'd1;
    round_sum = prod_r + ROUND_HALF;
    us_dec    = round_sum[43:12];
    enc_word  = enc_zero_r ? 16'd0 : {3'd0, enc_e_r, enc_v_r[7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_r      <= 16'd45056;
      guard_r    <= 16'd4528;
      enc_busy_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OSC) begin
          osc_r <= cfg_wdata;
        end else if (cfg_index == REG_GUARD) begin
          guard_r <= cfg_wdata;
        end
      end
      if (cmd.op == OP_ENC) begin
        enc_busy_r <= (div_q != 32'd0) && (enc_v0[31:8] != 24'd0);
      end else if (enc_busy_r) begin
        enc_busy_r <= (enc_v_r[31:9] != 23'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enc_busy_r) begin
      enc_v_r <= {1'b0, enc_v_r[31:1]};
      enc_e_r <= enc_e_r + 5'd1;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        kind_r   <= in_kind;
        code_a_r <= in_vcsel_period_a;
        code_b_r <= in_vcsel_period_b;
        enc_in_r <= in_encoded_timeout_a;
        le_r     <= (in_budget_us <= {16'd0, guard_r});
        big_r    <= (rem_full > MAX_REMAINDER_US);
        half_r   <= rem_full[20:1];
        status_r <= ST_OK;
        pc_r     <= '0;
        mma_r    <= '0;
        ra_r     <= '0;
        mmb_r    <= '0;
        rb_r     <= '0;
        bout_r   <= '0;
      end
      OP_FAIL1: status_r <= ST_LOW_BUDG;
      OP_FAIL2: status_r <= ST_HIGH_BUDG;
      OP_MAC1:  m1_r <= m1_prod[31:6];
      OP_MAC2:  macro_r <= {6'd0, m2_prod[31:6]};
      OP_ENC: begin
        enc_zero_r <= (div_q == 32'd0);
        enc_v_r    <= enc_v0;
        enc_e_r    <= '0;
      end
      OP_STORE: begin
        unique case (cmd.slot)
          SLOT_PC:  pc_r <= (div_q > 32'd255) ? PC_SAT : div_q[7:0];
          SLOT_MMA: mma_r <= enc_word;
          SLOT_RA:  ra_r <= enc_word;
          SLOT_MMB: mmb_r <= enc_word;
          default:  rb_r <= enc_word;
        endcase
      end
      OP_DMUL: prod_r <= {32'd0, dec_cnt} * {32'd0, macro_r};
      OP_DFIN: bout_r <= {us_dec[30:0], 1'b0} + {16'd0, guard_r};
      default: ;
    endcase
  end

  assign sts.kind     = kind_r;
  assign sts.le_guard = le_r;
  assign sts.too_big  = big_r;
  assign sts.div_busy = div_busy;
  assign sts.enc_busy = enc_busy_r;

  assign out_status           = status_r;
  assign out_phasecal_timeout = pc_r;
  assign out_mm_timeout_a     = mma_r;
  assign out_range_timeout_a  = ra_r;
  assign out_mm_timeout_b     = mmb_r;
  assign out_range_timeout_b  = rb_r;
  assign out_budget_out_us    = bout_r;

endmodule

// ===== hw/rtl/ltb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltb_ctrl
// Sequencer: walks one item through divider, multipliers and encoder.
// ----------------------------------------------------------------------------
module ltb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ltb_pkg::ltb_sts_t sts,
  output ltb_pkg::ltb_cmd_t cmd
);
  import ltb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PLL_W, S_MAC1, S_MAC2, S_CONV, S_CONV_W,
    S_ENC_W, S_STORE, S_DMUL, S_DFIN, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] slot_r, slot_nxt;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    cmd.op    = OP_NONE;
    cmd.slot  = slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          slot_nxt  = SLOT_PC;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.kind) begin
          cmd.op    = OP_PLL;
          state_nxt = S_PLL_W;
        end else if (sts.le_guard) begin
          cmd.op    = OP_FAIL1;
          state_nxt = S_DONE;
        end else if (sts.too_big) begin
          cmd.op    = OP_FAIL2;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_PLL;
          state_nxt = S_PLL_W;
        end
      end
      S_PLL_W: if (!sts.div_busy) state_nxt = S_MAC1;
      S_MAC1: begin
        cmd.op    = OP_MAC1;
        state_nxt = S_MAC2;
      end
      S_MAC2: begin
        cmd.op    = OP_MAC2;
        state_nxt = sts.kind ? S_DMUL : S_CONV;
      end
      S_CONV: begin
        cmd.op    = OP_CONV;
        state_nxt = S_CONV_W;
      end
      S_CONV_W: begin
        if (!sts.div_busy) begin
          // phasecal is stored raw, the rest go through the encoder
          if (slot_r == SLOT_PC) begin
            state_nxt = S_STORE;
          end else begin
            cmd.op    = OP_ENC;
            state_nxt = S_ENC_W;
          end
        end
      end
      S_ENC_W: if (!sts.enc_busy) state_nxt = S_STORE;
      S_STORE: begin
        cmd.op   = OP_STORE;
        slot_nxt = slot_r + 3'd1;
        priority if (slot_r == SLOT_RB) begin
          state_nxt = S_DONE;
        end else if (slot_r == SLOT_RA) begin
          state_nxt = S_MAC2;
        end else begin
          state_nxt = S_CONV;
        end
      end
      S_DMUL: begin
        cmd.op    = OP_DMUL;
        state_nxt = S_DFIN;
      end
      S_DFIN: begin
        cmd.op    = OP_DFIN;
        state_nxt = S_DONE;
      end
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= SLOT_PC;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ===== hw/rtl/lidar_timing_budget_calculator_core.sv =====
// An accepted budget runs six divisions on the shared bit-serial divider plus up
// to 24 normalization shifts per encoded value; a rejected budget uses no divider.
// One item in flight: a new item is taken only after the result is transferred.
// Reset (synchronous, rst_n low): sequencer idle, osc/guard registers to defaults.
// ----------------------------------------------------------------------------
// lidar_timing_budget_calculator_core
// Top level: sequencer, datapath and checks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lidar_timing_budget_calculator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_budget_us,
  input  logic [7:0]  in_vcsel_period_a,
  input  logic [7:0]  in_vcsel_period_b,
  input  logic [15:0] in_encoded_timeout_a,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_phasecal_timeout,
  output logic [15:0] out_mm_timeout_a,
  output logic [15:0] out_range_timeout_a,
  output logic [15:0] out_mm_timeout_b,
  output logic [15:0] out_range_timeout_b,
  output logic [31:0] out_budget_out_us
);
  import ltb_pkg::*;

  ltb_cmd_t cmd;
  ltb_sts_t sts;

  ltb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ltb_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_kind              (in_kind),
    .in_budget_us         (in_budget_us),
    .in_vcsel_period_a    (in_vcsel_period_a),
    .in_vcsel_period_b    (in_vcsel_period_b),
    .in_encoded_timeout_a (in_encoded_timeout_a),
    .out_status           (out_status),
    .out_phasecal_timeout (out_phasecal_timeout),
    .out_mm_timeout_a     (out_mm_timeout_a),
    .out_range_timeout_a  (out_range_timeout_a),
    .out_mm_timeout_b     (out_mm_timeout_b),
    .out_range_timeout_b  (out_range_timeout_b),
    .out_budget_out_us    (out_budget_out_us)
  );

  `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
  `ASSERT_NEXT(a_no_instant, clk, rst_n, in_valid && in_ready, !out_valid, "result without work")
  `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status != 2'd3, "bad status code")
  `ASSERT_IMPL(a_reject_zero, clk, rst_n, out_valid && (out_status != ST_OK), (out_phasecal_timeout == 8'd0) && (out_range_timeout_a == 16'd0) && (out_range_timeout_b == 16'd0) && (out_budget_out_us == 32'd0), "rejected item has nonzero fields")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timing budget calculator core.
// A driver feeds budget and decode items from a queue, a monitor compares every
// result with a model of the timeout arithmetic, and both sides idle randomly.
// ----------------------------------------------------------------------------
module tb;
  import ltb_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] budget;
    logic [7:0]  code_a;
    logic [7:0]  code_b;
    logic [15:0] enc_a;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  pc;
    logic [15:0] mm_a;
    logic [15:0] rng_a;
    logic [15:0] mm_b;
    logic [15:0] rng_b;
    logic [31:0] bud;
  } timeouts_t;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [31:0] in_budget_us;
  logic [7:0]  in_vcsel_period_a;
  logic [7:0]  in_vcsel_period_b;
  logic [15:0] in_encoded_timeout_a;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_phasecal_timeout;
  logic [15:0] out_mm_timeout_a;
  logic [15:0] out_range_timeout_a;
  logic [15:0] out_mm_timeout_b;
  logic [15:0] out_range_timeout_b;
  logic [31:0] out_budget_out_us;

  lidar_timing_budget_calculator_core dut (.*);

  logic [15:0] osc_q;
  logic [15:0] guard_q;
  item_t       pending_items[$];
  timeouts_t   expected_timeouts[$];
  int          fail_count;
  int          cycles;
  int          tx_gap;
  int          rx_gap;
  logic        in_done;
  logic        out_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] div_sat(logic [31:0] n, logic [31:0] d);
    return (d == 0) ? 32'hFFFF_FFFF : n / d;
  endfunction

  function automatic logic [31:0] macro_us(logic [7:0] code);
    logic [31:0] pll;
    logic [31:0] pclks;
    logic [31:0] m;
    pll = div_sat(PLL_NUM, {16'd0, osc_q});
    pclks = ((code + 32'd1) << 1) & 32'hFF;
    m = 32'd2304 * pll;
    m = m >> 6;
    m = m * pclks;
    return m >> 6;
  endfunction

  function automatic logic [31:0] us_to_macro(logic [31:0] us, logic [31:0] mac);
    return div_sat((us << 12) + (mac >> 1), mac);
  endfunction

  function automatic logic [15:0] encode_mclks(logic [31:0] m);
    logic [31:0] v;
    logic [31:0] e;
    if (m == 0) return 16'd0;
    v = m - 1;
    e = 0;
    while (v[31:8] != 0) begin
      v = v >> 1;
      e++;
    end
    return 16'(((e << 8) | (v & 32'hFF)));
  endfunction

  function automatic timeouts_t predict_timeouts(item_t it);
    timeouts_t r;
    logic [31:0] rem;
    logic [31:0] mac;
    logic [31:0] pc;
    logic [31:0] cnt;
    logic [63:0] p;
    r = '0;
    if (it.kind) begin
      mac = macro_us(it.code_a);
      cnt = (it.enc_a[15:8] >= 32) ? 32'd1
                                   : (({24'd0, it.enc_a[7:0]} << it.enc_a[15:8]) + 1);
      p = 64'(cnt) * 64'(mac) + ROUND_HALF;
      r.bud = 32'd2 * p[43:12] + {16'd0, guard_q};
      return r;
    end
    if (it.budget <= {16'd0, guard_q}) begin
      r.status = ST_LOW_BUDG;
      return r;
    end
    rem = it.budget - guard_q;
    if (rem > MAX_REMAINDER_US) begin
      r.status = ST_HIGH_BUDG;
      return r;
    end
    rem = rem / 2;
    mac = macro_us(it.code_a);
    pc = us_to_macro(PHASECAL_US, mac);
    r.pc = (pc > 255) ? PC_SAT : pc[7:0];
    r.mm_a = encode_mclks(us_to_macro(1, mac));
    r.rng_a = encode_mclks(us_to_macro(rem, mac));
    mac = macro_us(it.code_b);
    r.mm_b = encode_mclks(us_to_macro(1, mac));
    r.rng_b = encode_mclks(us_to_macro(rem, mac));
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  // driver
  always @(negedge clk) begin
    int g;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_done) begin
      // hold until transfer
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      item_t it;
      it = pending_items.pop_front();
      in_valid <= 1'b1;
      in_kind <= it.kind;
      in_budget_us <= it.budget;
      in_vcsel_period_a <= it.code_a;
      in_vcsel_period_b <= it.code_b;
      in_encoded_timeout_a <= it.enc_a;
      expected_timeouts.push_back(predict_timeouts(it));
      tx_gap <= $urandom_range(0, 9);
    end else begin
      in_valid <= 1'b0;
    end
    if (out_done) begin
      g = $urandom_range(0, 9);
      rx_gap <= (g > 0) ? g - 1 : 0;
      out_ready <= (g == 0);
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_done <= rst_n && in_valid && in_ready;
    out_done <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_timeouts.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        timeouts_t w;
        w = expected_timeouts.pop_front();
        if (out_status !== w.status) report("status", out_status, w.status);
        if (out_phasecal_timeout !== w.pc) report("phasecal", out_phasecal_timeout, w.pc);
        if (out_mm_timeout_a !== w.mm_a) report("mm_a", out_mm_timeout_a, w.mm_a);
        if (out_range_timeout_a !== w.rng_a) report("range_a", out_range_timeout_a, w.rng_a);
        if (out_mm_timeout_b !== w.mm_b) report("mm_b", out_mm_timeout_b, w.mm_b);
        if (out_range_timeout_b !== w.rng_b) report("range_b", out_range_timeout_b, w.rng_b);
        if (out_budget_out_us !== w.bud) report("budget", out_budget_out_us, w.bud);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic item_t rand_item();
    item_t it;
    it.kind = $urandom_range(0, 3) == 0;
    case ($urandom_range(0, 5))
      0: it.budget = $urandom();
      1: it.budget = $urandom_range(0, guard_q + 2);
      2: it.budget = guard_q + MAX_REMAINDER_US + $urandom_range(0, 2) - 1;
      default: it.budget = guard_q + $urandom_range(1, MAX_REMAINDER_US);
    endcase
    it.code_a = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 20));
    it.code_b = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 20));
    it.enc_a = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                           : {8'($urandom_range(0, 40)), 8'($urandom())};
    return it;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_OSC) osc_q = val;
    else if (idx == REG_GUARD) guard_q = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_timeouts.size() > 0 || in_valid)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    item_t it;
    logic [15:0] osc_set[5];
    logic [15:0] guard_set[5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_budget_us = '0;
    in_vcsel_period_a = '0;
    in_vcsel_period_b = '0;
    in_encoded_timeout_a = '0;
    out_ready = 1'b0;
    fail_count = 0;
    cycles = 0;
    tx_gap = 0;
    rx_gap = 0;
    osc_q = 16'd45056;
    guard_q = 16'd4528;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: guard edges, remainder limit, code wraps, exponent extremes
    pending_items.push_back('{1'b0, 32'd0, 8'd14, 8'd10, 16'd0});
    pending_items.push_back('{1'b0, 32'd4528, 8'd14, 8'd10, 16'd0});
    pending_items.push_back('{1'b0, 32'd4529, 8'd14, 8'd10, 16'd0});
    pending_items.push_back('{1'b0, 32'd4528 + MAX_REMAINDER_US, 8'd14, 8'd10, 16'd0});
    pending_items.push_back('{1'b0, 32'd4529 + MAX_REMAINDER_US, 8'd14, 8'd10, 16'd0});
    pending_items.push_back('{1'b0, 32'hFFFF_FFFF, 8'd0, 8'd0, 16'hFFFF});
    pending_items.push_back('{1'b0, 32'd200000, 8'd127, 8'd255, 16'd0});
    pending_items.push_back('{1'b0, 32'd200000, 8'd0, 8'd254, 16'd0});
    pending_items.push_back('{1'b1, 32'd0, 8'd14, 8'd0, 16'h0000});
    pending_items.push_back('{1'b1, 32'hFFFF_FFFF, 8'd255, 8'hFF, 16'hFFFF});
    pending_items.push_back('{1'b1, 32'd0, 8'd14, 8'd0, 16'h1FFF});
    pending_items.push_back('{1'b1, 32'd0, 8'd14, 8'd0, 16'h20FF});
    pending_items.push_back('{1'b1, 32'd0, 8'd127, 8'd0, 16'h0A55});
    drain();

    osc_set = '{16'd1, 16'd65535, 16'd45056, 16'd300, 16'd20000};
    guard_set = '{16'd0, 16'd65535, 16'd4528, 16'd1, 16'd1000};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_OSC, osc_set[ph]);
      write_reg(REG_GUARD, guard_set[ph]);
      if (ph == 3) write_reg(4'd9, 16'hFFFF);
      pending_items.push_back('{1'b0, {16'd0, guard_set[ph]}, 8'd5, 8'd7, 16'd0});
      pending_items.push_back('{1'b0, {16'd0, guard_set[ph]} + 1, 8'd5, 8'd7, 16'd0});
      for (int i = 0; i < 220; i++) begin
        it = rand_item();
        pending_items.push_back(it);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
